### rtl/prescaled_timer_bank_top_macros.svh
`ifndef PRESCALED_TIMER_BANK_TOP_MACROS_SVH
`define PRESCALED_TIMER_BANK_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define PTB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define PTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ptb_pkg.sv
package ptb_pkg;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_FREEZE = 2'd3;

  localparam logic [7:0] FREEZE_MIN   = 8'd2;
  localparam logic [7:0] WRAP_MARK    = 8'h80;
  localparam logic [6:0] RELOAD_RESET = 7'd20;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] timer_index;
    logic [7:0] write_value;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tick_frozen;
  } rsp_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_SWEEP = 2'd3
  } store_op_t;

  // addr and count are wide enough for any store depth up to 128
  typedef struct packed {
    store_op_t  op;
    logic [7:0] addr;
    logic [7:0] data;
    logic [7:0] count;
  } store_cmd_t;

  typedef struct packed {
    logic       done;
    logic [7:0] rdata;
  } store_stat_t;

endpackage

### rtl/ptb_store.sv
module ptb_store #(
  parameter int unsigned DEPTH = 35
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ptb_pkg::store_cmd_t  cmd,
  output ptb_pkg::store_stat_t stat
);
  import ptb_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld;

  logic          sweeping;
  logic [CW-1:0] ptr;
  logic [CW-1:0] lim;

  logic          pend;
  logic          pend_sweep;
  logic          pend_read;
  logic          pend_inr;
  logic          pend_last;
  logic [AW-1:0] pend_addr;

  logic [7:0] q;
  logic       q_vld;

  logic          cmd_inr;
  logic          sweep_rd;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    cur;
  logic [7:0]    dec;
  logic          we;
  logic [AW-1:0] wa;
  logic [7:0]    wd;

  assign cmd_inr = cmd.addr < 8'(DEPTH);

  always_comb begin
    sweep_rd = sweeping && (ptr < lim);
    rd_en    = 1'b0;
    rd_addr  = cmd.addr[AW-1:0];
    if (sweep_rd) begin
      rd_en   = 1'b1;
      rd_addr = ptr[AW-1:0];
    end else if (cmd.op == OP_READ && cmd_inr) begin
      rd_en = 1'b1;
    end
  end

  // unwritten entries read as zero
  assign cur = (pend_inr && q_vld) ? q : 8'd0;
  assign dec = cur - {7'd0, (cur != 8'd0)};

  always_comb begin
    we = 1'b0;
    wa = pend_addr;
    wd = dec;
    if (pend && pend_sweep) begin
      we = 1'b1;
    end else if (cmd.op == OP_WRITE && cmd_inr) begin
      we = 1'b1;
      wa = cmd.addr[AW-1:0];
      wd = cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      q     <= mem[rd_addr];
      q_vld <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping <= 1'b0;
      ptr      <= '0;
      lim      <= '0;
      pend     <= 1'b0;
    end else begin
      pend <= sweep_rd || cmd.op == OP_READ || cmd.op == OP_WRITE;
      if (cmd.op == OP_SWEEP) begin
        sweeping <= 1'b1;
        ptr      <= '0;
        lim      <= cmd.count[CW-1:0];
      end else if (sweep_rd) begin
        ptr <= ptr + 1'b1;
        if (ptr == lim - 1'b1) begin
          sweeping <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_sweep <= sweep_rd;
    pend_read  <= !sweep_rd && cmd.op == OP_READ;
    pend_inr   <= sweep_rd || cmd_inr;
    pend_addr  <= rd_addr;
    pend_last  <= sweep_rd && (ptr == lim - 1'b1);
  end

  assign stat.done  = pend && (!pend_sweep || pend_last);
  assign stat.rdata = pend_read ? cur : 8'd0;

endmodule

### rtl/prescaled_timer_bank_top.sv
// channel  | handshake          | payload
// ---------+--------------------+-------------------------------
// request  | start / busy       | req (type, timer index, value)
// result   | done (one cycle)   | rsp (read data, tick frozen)
// config   | cfg_we             | cfg_wdata (interval reload)
//
// One item at a time. Frozen tick, freeze count write: result in the cycle after accept.
// Timer read or write: busy for a single cycle, then the result, registered from the store.
// Unfrozen tick: read-modify-write pass over the timer memory, one entry per
// cycle; FAST_COUNT entries, or FAST_COUNT + SLOW_COUNT when the prescaler wraps.
// Reset is synchronous and needs no clearing pass. Results cannot be stalled.
module prescaled_timer_bank_top #(
  parameter int unsigned FAST_COUNT = 20,
  parameter int unsigned SLOW_COUNT = 15
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ptb_pkg::req_t req,
  output logic          done,
  output ptb_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic [6:0]    cfg_wdata
);
  import ptb_pkg::*;

  localparam int unsigned TOTAL = FAST_COUNT + SLOW_COUNT;

  typedef enum logic [1:0] {
    T_IDLE = 2'b01,
    T_WAIT = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic [7:0] freeze;
  logic [7:0] prescaler;
  logic [6:0] reload;

  logic        accept;
  logic        frozen_now;
  logic [7:0]  pre_dec;
  logic        wrap;
  store_cmd_t  cmd;
  store_stat_t stat;

  assign busy       = state == T_WAIT;
  assign accept     = start && !busy;
  assign frozen_now = freeze >= FREEZE_MIN;
  assign pre_dec    = prescaler - 8'd1;
  assign wrap       = pre_dec >= WRAP_MARK;

  always_comb begin
    cmd.op    = OP_NONE;
    cmd.addr  = {2'b00, req.timer_index};
    cmd.data  = req.write_value;
    cmd.count = wrap ? 8'(TOTAL) : 8'(FAST_COUNT);
    if (accept) begin
      case (req.req_type)
        REQ_TICK: begin
          if (!frozen_now) begin
            cmd.op = OP_SWEEP;
          end
        end
        REQ_WRITE: cmd.op = OP_WRITE;
        REQ_READ:  cmd.op = OP_READ;
        default:   cmd.op = OP_NONE;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      T_IDLE: begin
        if (cmd.op != OP_NONE) begin
          state_next = T_WAIT;
        end
      end
      T_WAIT: begin
        if (stat.done) begin
          state_next = T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
  end

  ptb_store #(
    .DEPTH(TOTAL)
  ) u_store (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .stat(stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      done      <= 1'b0;
      freeze    <= 8'd0;
      prescaler <= 8'd0;
      reload    <= RELOAD_RESET;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_we) begin
        reload <= cfg_wdata;
      end
      if (accept) begin
        case (req.req_type)
          REQ_TICK: begin
            if (frozen_now) begin
              freeze <= freeze - 8'd1;
              done   <= 1'b1;
            end else begin
              freeze    <= 8'd0;
              prescaler <= wrap ? {1'b0, reload} : pre_dec;
            end
          end
          REQ_FREEZE: begin
            freeze <= req.write_value;
            done   <= 1'b1;
          end
          default: ;
        endcase
      end
      if (state == T_WAIT && stat.done) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == T_WAIT && stat.done) begin
      rsp.read_data   <= stat.rdata;
      rsp.tick_frozen <= 1'b0;
    end else if (accept) begin
      rsp.read_data   <= 8'd0;
      rsp.tick_frozen <= req.req_type == REQ_TICK && frozen_now;
    end
  end

  `include "prescaled_timer_bank_top_macros.svh"

  `PTB_ASSERT_NEXT(a_item_answered, accept, done || busy, "item neither answered nor pending")
  `PTB_ASSERT_NOW(a_done_not_busy, done, !busy, "result shown while still busy")
  `PTB_ASSERT_NOW(a_frozen_no_data, done && rsp.tick_frozen, ~|rsp.read_data, "frozen with data")
  `PTB_ASSERT_NOW(a_store_done_waiting, stat.done, state == T_WAIT, "store done while idle")

endmodule
